// ===== hdl/skl_pkg.sv =====
// skl_pkg: shared types, widths and codes for the sorted key list.
// Used by skl_cmp and sorted_key_list; depends on nothing.

package skl_pkg;

    localparam int DEPTH   = 16;
    localparam int KEY_W   = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 40;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    // compare unit flags
    typedef struct packed {
        logic less;   // a < b, signed
        logic equal;  // a == b
    } skl_cmp_t;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_READ  = 5'b00100,
        S_EXEC  = 5'b01000,
        S_PLACE = 5'b10000
    } skl_state_t;

    // entry count as carried on the result bus (modulo 32)
    function automatic logic [ENTRY_W-1:0] cnt_to_field(input logic [CNT_W-1:0] c);
        cnt_to_field = ENTRY_W'(c);
    endfunction

endpackage

// ===== hdl/sorted_key_list.sv =====
// sorted_key_list: bounded table of signed keys kept in ascending order.
// Depends on skl_pkg and skl_cmp.
//
//  channel | ports                      | payload
//  --------+----------------------------+------------------------------------------
//  input   | s_tvalid s_tready s_tdata  | [1:0] opcode, [33:2] key, [39:34] zero
//  result  | m_tvalid m_tready m_tdata  | [1:0] status, [33:2] key_out,
//          | m_tlast                    | [38:34] entry_count, [39] zero; tlast=last
//
// Sequence: an item is taken only in idle, then a start state for setup and, per
// table entry visited, a read state then an exec state (compare/move) through
// the single memory read port and the one shared comparator, then back to idle.
// Delete and dump visit every stored entry; insert walks down from the top entry
// to the first smaller one, plus one place state when the key lands in the bottom
// slot.
// Reset clears the count, the sequencer, the found flag and the result valid
// only; the key memory is never cleared and is read only below the count.
// A stalled result bus holds the sequencer at its next result; nothing is lost.

module sorted_key_list (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [skl_pkg::IN_W-1:0]   s_tdata,   // opcode, key
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [skl_pkg::OUT_W-1:0]  m_tdata,   // status, key_out, entry_count
    output logic                       m_tlast
);

    localparam int KW = skl_pkg::KEY_W;
    localparam int IW = skl_pkg::IDX_W;
    localparam int CW = skl_pkg::CNT_W;

    // key memory: one write, one registered read
    logic [KW-1:0] mem [skl_pkg::DEPTH];

    skl_pkg::skl_state_t state_reg, state_next;
    logic [skl_pkg::OP_W-1:0]    op_reg, op_next;
    logic signed [KW-1:0]        key_reg, key_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic                        found_reg, found_next;
    logic [CW-1:0]               count_reg, count_next;
    logic signed [KW-1:0]        rd_data_reg;

    logic                        mem_we;
    logic [IW-1:0]               mem_waddr;
    logic [KW-1:0]               mem_wdata;

    // result register
    logic                        out_valid_reg;
    logic [skl_pkg::STAT_W-1:0]  out_status_reg;
    logic [KW-1:0]               out_key_reg;
    logic [skl_pkg::ENTRY_W-1:0] out_count_reg;
    logic                        out_last_reg;

    logic                        out_free;
    logic                        out_load;
    logic [skl_pkg::STAT_W-1:0]  res_status;
    logic [KW-1:0]               res_key;
    logic                        res_last;
    logic                        last_idx;
    logic                        hit;

    skl_pkg::skl_cmp_t           cmp;

    // the one comparator: stored entry against the item's key
    skl_cmp u_cmp (
        .a     (rd_data_reg),
        .b     (key_reg),
        .flags (cmp)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == skl_pkg::S_IDLE);
    assign last_idx = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign hit      = found_reg || cmp.equal;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = key_reg;
        out_load   = 1'b0;
        res_status = skl_pkg::ST_OK;
        res_key    = key_reg;
        res_last   = 1'b1;

        case (state_reg)
            skl_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[1:0];
                    key_next   = s_tdata[33:2];
                    state_next = skl_pkg::S_START;
                end
            end

            skl_pkg::S_START: begin
                case (op_reg)
                    skl_pkg::OP_INSERT: begin
                        if (count_reg >= CW'(skl_pkg::DEPTH)) begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                res_status = skl_pkg::ST_FULL;
                                state_next = skl_pkg::S_IDLE;
                            end
                        end else if (count_reg == '0) begin
                            state_next = skl_pkg::S_PLACE;
                        end else begin
                            // walk down from the top entry
                            idx_next   = IW'(count_reg - CW'(1));
                            state_next = skl_pkg::S_READ;
                        end
                    end
                    skl_pkg::OP_DELETE: begin
                        if (count_reg == '0) begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                res_status = skl_pkg::ST_NOT_FOUND;
                                state_next = skl_pkg::S_IDLE;
                            end
                        end else begin
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = skl_pkg::S_READ;
                        end
                    end
                    skl_pkg::OP_DUMP: begin
                        if (count_reg == '0) begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                res_status = skl_pkg::ST_EMPTY;
                                state_next = skl_pkg::S_IDLE;
                            end
                        end else begin
                            idx_next   = '0;
                            state_next = skl_pkg::S_READ;
                        end
                    end
                    default: begin
                        state_next = skl_pkg::S_IDLE;
                    end
                endcase
            end

            skl_pkg::S_READ: begin
                state_next = skl_pkg::S_EXEC;
            end

            skl_pkg::S_EXEC: begin
                case (op_reg)
                    skl_pkg::OP_INSERT: begin
                        if (cmp.less) begin
                            // slot found just above this entry
                            if (out_free) begin
                                mem_we     = 1'b1;
                                mem_waddr  = idx_reg + IW'(1);
                                mem_wdata  = key_reg;
                                count_next = count_reg + CW'(1);
                                out_load   = 1'b1;
                                state_next = skl_pkg::S_IDLE;
                            end
                        end else begin
                            // entry not smaller: move it up one place
                            mem_we    = 1'b1;
                            mem_waddr = idx_reg + IW'(1);
                            mem_wdata = rd_data_reg;
                            if (idx_reg == '0) begin
                                state_next = skl_pkg::S_PLACE;
                            end else begin
                                idx_next   = idx_reg - IW'(1);
                                state_next = skl_pkg::S_READ;
                            end
                        end
                    end
                    skl_pkg::OP_DELETE: begin
                        if (!last_idx || out_free) begin
                            // entries after the first match close the gap
                            if (found_reg) begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_reg - IW'(1);
                                mem_wdata = rd_data_reg;
                            end
                            found_next = hit;
                            if (last_idx) begin
                                out_load = 1'b1;
                                if (hit) begin
                                    count_next = count_reg - CW'(1);
                                end else begin
                                    res_status = skl_pkg::ST_NOT_FOUND;
                                end
                                state_next = skl_pkg::S_IDLE;
                            end else begin
                                idx_next   = idx_reg + IW'(1);
                                state_next = skl_pkg::S_READ;
                            end
                        end
                    end
                    skl_pkg::OP_DUMP: begin
                        if (out_free) begin
                            out_load = 1'b1;
                            res_key  = rd_data_reg;
                            res_last = last_idx;
                            if (last_idx) begin
                                state_next = skl_pkg::S_IDLE;
                            end else begin
                                idx_next   = idx_reg + IW'(1);
                                state_next = skl_pkg::S_READ;
                            end
                        end
                    end
                    default: begin
                        state_next = skl_pkg::S_IDLE;
                    end
                endcase
            end

            skl_pkg::S_PLACE: begin
                // key goes to the bottom slot
                if (out_free) begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = key_reg;
                    count_next = count_reg + CW'(1);
                    out_load   = 1'b1;
                    state_next = skl_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = skl_pkg::S_IDLE;
            end
        endcase
    end

    // key memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == skl_pkg::S_READ) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // sequencer and table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skl_pkg::S_IDLE;
            count_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            found_reg <= found_next;
        end
        op_reg  <= op_next;
        key_reg <= key_next;
        idx_reg <= idx_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            out_status_reg <= res_status;
            out_key_reg    <= res_key;
            out_count_reg  <= skl_pkg::cnt_to_field(count_next);
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_key_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/skl_cmp.sv =====
// skl_cmp: the shared signed key comparator of the sorted key list.
// Depends on skl_pkg.

module skl_cmp (
    input  logic signed [skl_pkg::KEY_W-1:0] a,
    input  logic signed [skl_pkg::KEY_W-1:0] b,
    output skl_pkg::skl_cmp_t                flags
);

    always_comb begin
        flags.less  = (a < b);
        flags.equal = (a == b);
    end

endmodule

// ===== dv/sorted_key_list_tb.sv =====
`timescale 1ns / 1ps
// sorted_key_list_tb: self-checking bench for the sorted key list, with its own
// table predictor and random stream stalls. Depends on skl_pkg and sorted_key_list.

module sorted_key_list_tb;

    localparam int KW = skl_pkg::KEY_W;
    localparam int EW = skl_pkg::ENTRY_W;
    localparam int DW = skl_pkg::IN_W;

    // opcode that the block drops without a result
    localparam logic [skl_pkg::OP_W-1:0] OP_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 80;       // well above the longest item on a free result bus
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [skl_pkg::OP_W-1:0] op;
        logic [KW-1:0]            key;
        logic                     wait_idle;    // hold back until every result is in
    } list_cmd_t;

    typedef struct packed {
        logic [skl_pkg::STAT_W-1:0] status;
        logic [KW-1:0]              key;
        logic [EW-1:0]              count;
        logic                       last;
    } list_result_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [DW-1:0]             s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [skl_pkg::OUT_W-1:0] m_tdata;
    logic                      m_tlast;

    // predictor copy of the table
    logic signed [KW-1:0] table_keys [skl_pkg::DEPTH];
    int                   table_count = 0;

    list_cmd_t    cmd_queue [$];
    list_result_t expected_results [$];
    list_cmd_t    cur_cmd;
    logic         have_cmd = 1'b0;

    int n_accepted   = 0;
    int n_results    = 0;
    int n_fail       = 0;
    int cycles       = 0;
    int tx_gap       = 0;
    int rx_gap       = 0;
    int tx_pct       = 15;
    int rx_pct       = 15;
    int hold_left    = 0;
    int holds_done   = 0;
    int next_hold_at = 40;

    sorted_key_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // opcode, key
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // status, key_out, entry_count
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // idle density per stretch: none, light or heavy
    function automatic int pick_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 15;
            default: return 50;
        endcase
    endfunction

    // full-range key, biased toward the sign and range edges
    function automatic logic [KW-1:0] rand_key();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_cmd(logic [skl_pkg::OP_W-1:0] op, logic [KW-1:0] key,
                                     logic wait_idle);
        list_cmd_t c;
        c.op        = op;
        c.key       = key;
        c.wait_idle = wait_idle;
        cmd_queue.push_back(c);
    endfunction

    function automatic void push_result(logic [skl_pkg::STAT_W-1:0] status,
                                        logic [KW-1:0] key, logic last);
        list_result_t r;
        r.status = status;
        r.key    = key;
        r.count  = EW'(table_count);
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    // Table update and expected items for one accepted command.
    // Insert goes before the first entry not smaller (signed); delete takes the
    // first equal entry; dump walks the table in order, tlast on the final one.
    function automatic void predict_results(logic [skl_pkg::OP_W-1:0] op,
                                            logic signed [KW-1:0] key);
        int pos;
        case (op)
            skl_pkg::OP_INSERT: begin
                if (table_count >= skl_pkg::DEPTH) begin
                    push_result(skl_pkg::ST_FULL, key, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < table_count && table_keys[pos] < key)
                        pos++;
                    for (int i = table_count; i > pos; i--)
                        table_keys[i] = table_keys[i-1];
                    table_keys[pos] = key;
                    table_count++;
                    push_result(skl_pkg::ST_OK, key, 1'b1);
                end
            end
            skl_pkg::OP_DELETE: begin
                pos = 0;
                while (pos < table_count && table_keys[pos] != key)
                    pos++;
                if (pos >= table_count) begin
                    push_result(skl_pkg::ST_NOT_FOUND, key, 1'b1);
                end else begin
                    for (int i = pos; i + 1 < table_count; i++)
                        table_keys[i] = table_keys[i+1];
                    table_count--;
                    push_result(skl_pkg::ST_OK, key, 1'b1);
                end
            end
            skl_pkg::OP_DUMP: begin
                if (table_count == 0) begin
                    push_result(skl_pkg::ST_EMPTY, key, 1'b1);
                end else begin
                    for (int i = 0; i < table_count; i++)
                        push_result(skl_pkg::ST_OK, table_keys[i], i + 1 == table_count);
                end
            end
            default: ;  // dropped opcode: nothing comes back
        endcase
    endfunction

    // print capped so a broken build cannot flood the log
    task automatic report_mismatch(string what, logic [KW-1:0] got, logic [KW-1:0] want);
        if (n_fail < 100)
            $display("mismatch: %s got %0h want %0h (result item %0d, cycle %0d)",
                     what, got, want, n_results, cycles);
        n_fail++;
    endtask

    // ---------------------------------------------------------------
    // reset and watchdog
    // ---------------------------------------------------------------

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL sorted_key_list");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // driver: one command per handshake, random gaps between items.
    // tvalid stays up until the item is taken; a command flagged wait_idle
    // is held back until the table has returned every expected item.
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            have_cmd = 1'b0;
            tx_gap   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_results(cur_cmd.op, cur_cmd.key);
                n_accepted <= n_accepted + 1;
                have_cmd = 1'b0;
                if ($urandom_range(99) < tx_pct)
                    tx_gap = pick_gap();
                if (n_accepted % 50 == 49)
                    tx_pct = pick_pct();
            end
            if (!have_cmd) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (cmd_queue.size() != 0 &&
                             (!cmd_queue[0].wait_idle || expected_results.size() == 0)) begin
                    cur_cmd  = cmd_queue.pop_front();
                    have_cmd = 1'b1;
                end
            end
            s_tvalid <= have_cmd;
            s_tdata  <= DW'({cur_cmd.key, cur_cmd.op});
        end
    end

    // ---------------------------------------------------------------
    // long receiver hold-off: twice in the run, tready drops for a long
    // stretch while the driver keeps offering, so the input backs up
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && n_accepted >= next_hold_at) begin
            hold_left    <= 300;
            holds_done   <= holds_done + 1;
            next_hold_at <= next_hold_at + 90;
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks each taken item against the oldest expectation,
    // and drives tready with random stalls
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        list_result_t want;
        logic         rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item, key_out", m_tdata[33:2], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", KW'(m_tdata[1:0]), KW'(want.status));
                    if (m_tdata[33:2] !== want.key)
                        report_mismatch("key_out", m_tdata[33:2], want.key);
                    if (m_tdata[38:34] !== want.count)
                        report_mismatch("entry_count", KW'(m_tdata[38:34]), KW'(want.count));
                    if (m_tlast !== want.last)
                        report_mismatch("tlast", KW'(m_tlast), KW'(want.last));
                end
                n_results++;
                if (n_results % 60 == 0)
                    rx_pct = pick_pct();
            end
            if (rx_gap != 0) begin
                rx_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if ($urandom_range(99) < rx_pct)
                    rx_gap = pick_gap();
            end
            m_tready <= rdy && (hold_left == 0);
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------

    initial begin
        logic [KW-1:0]            pool [6];
        logic [skl_pkg::OP_W-1:0] op;
        logic [KW-1:0]            key;
        int                       n_real;
        int                       phase;
        int                       roll;
        int                       ins_pct;
        int                       del_pct;

        // directed: empty-table cases, a dropped opcode, range extremes,
        // duplicates, first-equal delete, missing key, fill to full and
        // an insert into the full table, then a full dump
        push_cmd(skl_pkg::OP_DUMP,   32'h1357_9bdf, 1'b0);
        push_cmd(skl_pkg::OP_DELETE, 32'hffff_ffff, 1'b0);
        push_cmd(OP_NONE,            32'hdead_beef, 1'b0);
        push_cmd(skl_pkg::OP_INSERT, 32'h0000_0000, 1'b0);
        push_cmd(skl_pkg::OP_INSERT, 32'h7fff_ffff, 1'b0);
        push_cmd(skl_pkg::OP_INSERT, 32'h8000_0000, 1'b0);
        push_cmd(skl_pkg::OP_INSERT, 32'hffff_ffff, 1'b0);
        push_cmd(skl_pkg::OP_INSERT, 32'h0000_0005, 1'b0);
        push_cmd(skl_pkg::OP_INSERT, 32'h0000_0005, 1'b0);
        push_cmd(skl_pkg::OP_DUMP,   32'h0000_0000, 1'b0);
        push_cmd(skl_pkg::OP_DELETE, 32'h0000_0005, 1'b0);
        push_cmd(skl_pkg::OP_DELETE, 32'h0000_0007, 1'b0);
        for (int i = 0; i < skl_pkg::DEPTH - 5; i++)
            push_cmd(skl_pkg::OP_INSERT, $urandom, 1'b0);
        push_cmd(skl_pkg::OP_INSERT, 32'h1234_5678, 1'b0);
        push_cmd(skl_pkg::OP_DUMP,   32'h0000_0000, 1'b0);
        push_cmd(skl_pkg::OP_DELETE, 32'h7fff_ffff, 1'b0);

        // random: stretches that lean to filling, draining or mixing, keys
        // mostly from a small slowly changing pool so deletes hit and
        // duplicates pile up
        foreach (pool[i])
            pool[i] = rand_key();
        n_real = 0;
        phase  = 0;
        while (n_real < RANDOM_ITEMS) begin
            if (n_real % 25 == 0) begin
                phase = $urandom_range(2);
                pool[$urandom_range(5)] = rand_key();
            end
            ins_pct = (phase == 0) ? 70 : (phase == 1) ? 20 : 45;
            del_pct = (phase == 0) ? 15 : (phase == 1) ? 65 : 40;
            roll = $urandom_range(99);
            if (roll < ins_pct)
                op = skl_pkg::OP_INSERT;
            else if (roll < ins_pct + del_pct)
                op = skl_pkg::OP_DELETE;
            else if (roll < 95)
                op = skl_pkg::OP_DUMP;
            else
                op = OP_NONE;
            key = ($urandom_range(3) != 0) ? pool[$urandom_range(5)] : rand_key();
            push_cmd(op, key, n_real == 0 || $urandom_range(39) == 0);
            if (op != OP_NONE)
                n_real++;
        end

        while (cmd_queue.size() != 0 || have_cmd)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_fail == 0) begin
            $display("PASS sorted_key_list");
        end else begin
            $display("FAIL sorted_key_list");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/skl_pkg.sv
hdl/skl_cmp.sv
hdl/sorted_key_list.sv
dv/sorted_key_list_tb.sv
